// ----- rtl/rhsc_pkg.sv -----
// Package for the RGB to HSV skin classifier.
// Beat type handed along the divider chain, register indexes and reset values.
`timescale 1ns / 1ps
package rhsc_pkg;

  localparam int unsigned PixW   = 8;
  localparam int unsigned QuotW  = 8;
  localparam int unsigned HueNumW = 20;
  localparam int unsigned HueDivW = 19;
  localparam int unsigned SatNumW = 17;
  localparam int unsigned SatDivW = 16;

  localparam logic [PixW-1:0] HueThrReset = 8'd92;
  localparam logic [PixW-1:0] SatThrReset = 8'd54;

  typedef enum logic {
    REG_HUE_THRESHOLD = 1'b0,
    REG_SAT_THRESHOLD = 1'b1
  } rhsc_reg_t;

  typedef struct packed {
    logic [HueNumW-1:0] hue_rem;
    logic [HueDivW-1:0] hue_div;
    logic [QuotW-1:0]   hue_q;
    logic [SatNumW-1:0] sat_rem;
    logic [SatDivW-1:0] sat_div;
    logic [QuotW-1:0]   sat_q;
    logic [PixW-1:0]    bright;
    logic               hue_zero;
    logic               sat_zero;
  } rhsc_beat_t;

endpackage

// ----- rtl/rhsc_prep.sv -----
// Front stage: max, min, delta and hue sector numerator of one pixel.
// Emits the first beat of the divider chain. Depends on rhsc_pkg.
`timescale 1ns / 1ps
module rhsc_prep import rhsc_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            up_valid,
  output logic            up_ready,
  input  logic [PixW-1:0] red,
  input  logic [PixW-1:0] green,
  input  logic [PixW-1:0] blue,
  output logic            dn_valid,
  input  logic            dn_ready,
  output rhsc_beat_t      dn_beat
);

  logic            valid_r, valid_nxt;
  logic [PixW-1:0] mx_r, mx_nxt;
  logic [PixW-1:0] d_r, d_nxt;
  logic [10:0]     n_r, n_nxt;
  logic            hz_r, hz_nxt;
  logic            sz_r, sz_nxt;
  logic [PixW-1:0] mn;
  logic [10:0]     d_ext;
  logic [11:0]     d12;
  logic [HueNumW-1:0] n_ext;
  logic [HueNumW-1:0] d_ext20;

  assign up_ready = !valid_r || dn_ready;

  always_comb begin
    mx_nxt = (red > green) ? red : green;
    if (blue > mx_nxt) begin
      mx_nxt = blue;
    end
    mn = (red < green) ? red : green;
    if (blue < mn) begin
      mn = blue;
    end
    d_nxt = mx_nxt - mn;
    d_ext = {3'b0, d_nxt};
    if (mx_nxt == red) begin
      if (green >= blue) begin
        n_nxt = {3'b0, green} - {3'b0, blue};
      end else begin
        n_nxt = (d_ext << 2) + (d_ext << 1) - ({3'b0, blue} - {3'b0, green});
      end
    end else if (mx_nxt == green) begin
      n_nxt = (d_ext << 1) + {3'b0, blue} - {3'b0, red};
    end else begin
      n_nxt = (d_ext << 2) + {3'b0, red} - {3'b0, green};
    end
    sz_nxt    = (mx_nxt == '0);
    hz_nxt    = (d_nxt == '0);
    valid_nxt = up_ready ? up_valid : valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      mx_r <= mx_nxt;
      d_r  <= d_nxt;
      n_r  <= n_nxt;
      hz_r <= hz_nxt;
      sz_r <= sz_nxt;
    end
  end

  // numerators 510*n + 6*d and 510*d + mx; divisors 12*d and 2*mx, pre-shifted by 7
  always_comb begin
    n_ext   = {9'b0, n_r};
    d_ext20 = {12'b0, d_r};
    d12     = ({4'b0, d_r} << 3) + ({4'b0, d_r} << 2);
    dn_beat.hue_rem  = (n_ext << 9) - (n_ext << 1) + (d_ext20 << 2) + (d_ext20 << 1);
    dn_beat.hue_div  = {d12, 7'b0};
    dn_beat.hue_q    = '0;
    dn_beat.sat_rem  = ({9'b0, d_r} << 9) - ({9'b0, d_r} << 1) + {9'b0, mx_r};
    dn_beat.sat_div  = {mx_r, 8'b0};
    dn_beat.sat_q    = '0;
    dn_beat.bright   = mx_r;
    dn_beat.hue_zero = hz_r;
    dn_beat.sat_zero = sz_r;
  end

  assign dn_valid = valid_r;

endmodule

// ----- rtl/rhsc_cell.sv -----
// One restoring division cell: one quotient bit for the hue and saturation lanes.
// Divisors move right one place per cell. Depends on rhsc_pkg.
`timescale 1ns / 1ps
module rhsc_cell import rhsc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       up_valid,
  output logic       up_ready,
  input  rhsc_beat_t up_beat,
  output logic       dn_valid,
  input  logic       dn_ready,
  output rhsc_beat_t dn_beat
);

  logic       valid_r, valid_nxt;
  rhsc_beat_t beat_r, beat_nxt;
  logic       hue_ge, sat_ge;

  assign up_ready = !valid_r || dn_ready;

  always_comb begin
    hue_ge   = up_beat.hue_rem >= {1'b0, up_beat.hue_div};
    sat_ge   = up_beat.sat_rem >= {1'b0, up_beat.sat_div};
    beat_nxt = up_beat;
    beat_nxt.hue_rem = hue_ge ? up_beat.hue_rem - {1'b0, up_beat.hue_div} : up_beat.hue_rem;
    beat_nxt.sat_rem = sat_ge ? up_beat.sat_rem - {1'b0, up_beat.sat_div} : up_beat.sat_rem;
    beat_nxt.hue_div = up_beat.hue_div >> 1;
    beat_nxt.sat_div = up_beat.sat_div >> 1;
    beat_nxt.hue_q   = {up_beat.hue_q[QuotW-2:0], hue_ge};
    beat_nxt.sat_q   = {up_beat.sat_q[QuotW-2:0], sat_ge};
    valid_nxt = up_ready ? up_valid : valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      beat_r <= beat_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_beat  = beat_r;

endmodule

// ----- rtl/rgb_to_hsv_skin_classifier_top.sv -----
// Top level of the RGB to HSV skin classifier.
// Uses rhsc_pkg, rhsc_prep and rhsc_cell.
//
// Input channel in_valid/in_ready carries one RGB pixel per beat; the result
// channel out_valid/out_ready returns hue, saturation, brightness and the
// skin flag for each pixel in order. cfg_we writes a threshold at cfg_index.
// One pixel per cycle sustained while out_ready stays high. The pipeline is
// one front stage for max/min/delta, then a chain of 8 division cells, each
// settling one quotient bit of both hue and saturation.
// Every stage holds its own valid bit, so bubbles close up and input is taken
// while a finished result waits; in_ready drops only once all stages are full
// and out_ready is low. Results are held stable while stalled.
// Reset clears all valid bits and loads the thresholds with 92 and 54.
`timescale 1ns / 1ps
module rgb_to_hsv_skin_classifier_top import rhsc_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [PixW-1:0] in_red,
  input  logic [PixW-1:0] in_green,
  input  logic [PixW-1:0] in_blue,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [PixW-1:0] out_hue,
  output logic [PixW-1:0] out_saturation,
  output logic [PixW-1:0] out_brightness,
  output logic            out_skin_flag,
  input  logic            cfg_we,
  input  logic            cfg_index,
  input  logic [PixW-1:0] cfg_data
);

  localparam int unsigned NumCells = QuotW;

  logic [PixW-1:0] hue_thr_r, hue_thr_nxt;
  logic [PixW-1:0] sat_thr_r, sat_thr_nxt;

  logic       chain_valid [NumCells+1];
  logic       chain_ready [NumCells+1];
  rhsc_beat_t chain_beat  [NumCells+1];

  always_comb begin
    hue_thr_nxt = hue_thr_r;
    sat_thr_nxt = sat_thr_r;
    if (cfg_we) begin
      unique case (rhsc_reg_t'(cfg_index))
        REG_HUE_THRESHOLD: hue_thr_nxt = cfg_data;
        REG_SAT_THRESHOLD: sat_thr_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hue_thr_r <= HueThrReset;
      sat_thr_r <= SatThrReset;
    end else begin
      hue_thr_r <= hue_thr_nxt;
      sat_thr_r <= sat_thr_nxt;
    end
  end

  rhsc_prep u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_ready (in_ready),
    .red      (in_red),
    .green    (in_green),
    .blue     (in_blue),
    .dn_valid (chain_valid[0]),
    .dn_ready (chain_ready[0]),
    .dn_beat  (chain_beat[0])
  );

  for (genvar k = 0; k < NumCells; k++) begin : g_cell
    rhsc_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (chain_valid[k]),
      .up_ready (chain_ready[k]),
      .up_beat  (chain_beat[k]),
      .dn_valid (chain_valid[k+1]),
      .dn_ready (chain_ready[k+1]),
      .dn_beat  (chain_beat[k+1])
    );
  end

  assign chain_ready[NumCells] = out_ready;
  assign out_valid      = chain_valid[NumCells];
  assign out_hue        = chain_beat[NumCells].hue_zero ? '0 : chain_beat[NumCells].hue_q;
  assign out_saturation = chain_beat[NumCells].sat_zero ? '0 : chain_beat[NumCells].sat_q;
  assign out_brightness = chain_beat[NumCells].bright;
  assign out_skin_flag  = (out_hue >= hue_thr_r) && (out_saturation >= sat_thr_r);

  // stall only when the whole chain is backed up
  a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready))
    else $error("in_ready low while output side free");

  // zero saturation means a grey or black pixel, so hue must be zero
  a_grey_hue: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_saturation == '0) |-> (out_hue == '0))
    else $error("nonzero hue with zero saturation");

  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> chain_valid[0])
    else $error("accepted pixel not in front stage");

endmodule

// ----- dv/rgb_to_hsv_skin_classifier_top_test.sv -----
// Testbench for the RGB to HSV skin classifier: a scoreboard predicts each pixel
// and checks the result stream; plain tasks drive pixels, thresholds and stalls.
// Depends on rhsc_pkg and rgb_to_hsv_skin_classifier_top.
`timescale 1ns / 1ps
module rgb_to_hsv_skin_classifier_top_test import rhsc_pkg::*; ;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned SettleCycles = 20;
  localparam int unsigned HoldCycles = 150;

  typedef struct packed {
    logic [PixW-1:0] red;
    logic [PixW-1:0] green;
    logic [PixW-1:0] blue;
    logic [PixW-1:0] hue;
    logic [PixW-1:0] saturation;
    logic [PixW-1:0] brightness;
    logic            skin_flag;
  } hsv_expect_t;

  class pixel_scoreboard;
    hsv_expect_t hsv_q[$];
    logic [PixW-1:0] hue_thr = HueThrReset;
    logic [PixW-1:0] sat_thr = SatThrReset;
    int unsigned mismatches = 0;

    function void set_threshold(rhsc_reg_t idx, logic [PixW-1:0] val);
      case (idx)
        REG_HUE_THRESHOLD: hue_thr = val;
        REG_SAT_THRESHOLD: sat_thr = val;
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return hsv_q.size();
    endfunction

    function hsv_expect_t convert_pixel(logic [PixW-1:0] r, logic [PixW-1:0] g,
                                        logic [PixW-1:0] b);
      int unsigned rv, gv, bv, mx, mn, d, n, h, s;
      hsv_expect_t res;
      rv = 32'(r);
      gv = 32'(g);
      bv = 32'(b);
      mx = (rv > gv) ? rv : gv;
      mx = (mx > bv) ? mx : bv;
      mn = (rv < gv) ? rv : gv;
      mn = (mn < bv) ? mn : bv;
      d = mx - mn;
      h = 0;
      s = 0;
      if (mx != 0) begin
        s = (510 * d + mx) / (2 * mx);
        if (s > 255) s = 255;
        if (d != 0) begin
          // red wins ties, then green
          if (mx == rv) begin
            n = (gv >= bv) ? gv - bv : 6 * d - (bv - gv);
          end else if (mx == gv) begin
            n = 2 * d + bv - rv;
          end else begin
            n = 4 * d + rv - gv;
          end
          h = (510 * n + 6 * d) / (12 * d);
          if (h > 255) h = 255;
        end
      end
      res.red = r;
      res.green = g;
      res.blue = b;
      res.hue = h[PixW-1:0];
      res.saturation = s[PixW-1:0];
      res.brightness = mx[PixW-1:0];
      res.skin_flag = (h >= 32'(hue_thr)) && (s >= 32'(sat_thr));
      return res;
    endfunction

    function void note_pixel(logic [PixW-1:0] r, logic [PixW-1:0] g, logic [PixW-1:0] b);
      hsv_q.push_back(convert_pixel(r, g, b));
    endfunction

    function void check_result(logic [PixW-1:0] hue, logic [PixW-1:0] sat,
                               logic [PixW-1:0] bright, logic skin);
      hsv_expect_t exp_hsv;
      if (hsv_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result with nothing pending: h=%0d s=%0d v=%0d skin=%0b",
                   $realtime, hue, sat, bright, skin);
        return;
      end
      exp_hsv = hsv_q.pop_front();
      if (hue !== exp_hsv.hue || sat !== exp_hsv.saturation ||
          bright !== exp_hsv.brightness || skin !== exp_hsv.skin_flag) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"%0t: rgb=(%0d,%0d,%0d) exp h=%0d s=%0d v=%0d skin=%0b,",
                    " got h=%0d s=%0d v=%0d skin=%0b"},
                   $realtime, exp_hsv.red, exp_hsv.green, exp_hsv.blue,
                   exp_hsv.hue, exp_hsv.saturation, exp_hsv.brightness, exp_hsv.skin_flag,
                   hue, sat, bright, skin);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [PixW-1:0] in_red = '0;
  logic [PixW-1:0] in_green = '0;
  logic [PixW-1:0] in_blue = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [PixW-1:0] out_hue;
  logic [PixW-1:0] out_saturation;
  logic [PixW-1:0] out_brightness;
  logic out_skin_flag;
  logic cfg_we = 1'b0;
  rhsc_reg_t cfg_index = REG_HUE_THRESHOLD;
  logic [PixW-1:0] cfg_data = '0;

  pixel_scoreboard sb = new;
  int unsigned send_idle_pct = 34;
  int unsigned recv_idle_pct = 72;
  bit hold_request = 1'b0;
  bit hold_done = 1'b0;
  int unsigned hold_left = 0;
  int unsigned cycles = 0;

  rgb_to_hsv_skin_classifier_top i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_red        (in_red),
    .in_green      (in_green),
    .in_blue       (in_blue),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_hue       (out_hue),
    .out_saturation(out_saturation),
    .out_brightness(out_brightness),
    .out_skin_flag (out_skin_flag),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // receiver: random back-pressure plus one long hold-off
  always @(negedge clk) begin
    if (hold_request && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result(out_hue, out_saturation, out_brightness, out_skin_flag);
  end

  // called and returns at a falling edge
  task automatic send_pixel(logic [PixW-1:0] r, logic [PixW-1:0] g, logic [PixW-1:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_red <= r;
    in_green <= g;
    in_blue <= b;
    do @(posedge clk); while (!in_ready);
    sb.note_pixel(r, g, b);
    @(negedge clk);
  endtask

  task automatic send_random_pixel();
    logic [PixW-1:0] r, g, b, hi;
    r = PixW'($urandom_range(255));
    g = PixW'($urandom_range(255));
    b = PixW'($urandom_range(255));
    hi = PixW'($urandom_range(255));
    case ($urandom_range(9))
      5: begin
        g = r;
        b = r;
      end
      6: begin
        case ($urandom_range(2))
          0: begin r = hi; g = hi; b = PixW'($urandom_range(hi)); end
          1: begin g = hi; b = hi; r = PixW'($urandom_range(hi)); end
          default: begin r = hi; b = hi; g = PixW'($urandom_range(hi)); end
        endcase
      end
      7: begin
        r = PixW'($urandom_range(255, 120));
        g = PixW'($urandom_range(r, 40));
        b = PixW'($urandom_range(g, 0));
      end
      8: begin
        r = PixW'($urandom_range(1) ? 255 - $urandom_range(1) : $urandom_range(1));
        g = PixW'($urandom_range(1) ? 255 - $urandom_range(1) : $urandom_range(1));
        b = PixW'($urandom_range(1) ? 255 - $urandom_range(1) : $urandom_range(1));
      end
      9: begin
        g = PixW'((r > 252) ? r - $urandom_range(3) : r + $urandom_range(3));
        b = PixW'((r > 252) ? r - $urandom_range(3) : r + $urandom_range(3));
      end
      default: ;
    endcase
    send_pixel(r, g, b);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() > 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic write_threshold(rhsc_reg_t idx, logic [PixW-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    sb.set_threshold(idx, val);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic random_phase(int unsigned count);
    repeat (count) send_random_pixel();
    drain();
  endtask

  initial begin
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset thresholds; corners, ties, hue wrap and clip
    send_idle_pct = 34;
    recv_idle_pct = 72;
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd128, 8'd128, 8'd128);
    send_pixel(8'd1, 8'd1, 8'd1);
    send_pixel(8'd255, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd255);
    send_pixel(8'd255, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd1);
    send_pixel(8'd255, 8'd1, 8'd0);
    send_pixel(8'd1, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd1, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd1);
    send_pixel(8'd255, 8'd254, 8'd254);
    send_pixel(8'd220, 8'd160, 8'd120);
    send_pixel(8'd200, 8'd100, 8'd50);
    send_pixel(8'd170, 8'd85, 8'd0);
    send_pixel(8'd100, 8'd200, 8'd250);
    drain();

    // zero thresholds: black and grey raise the flag
    write_threshold(REG_HUE_THRESHOLD, 8'd0);
    write_threshold(REG_SAT_THRESHOLD, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd77, 8'd77, 8'd77);
    random_phase(150);

    send_idle_pct = 72;
    recv_idle_pct = 34;
    write_threshold(REG_HUE_THRESHOLD, 8'd255);
    write_threshold(REG_SAT_THRESHOLD, 8'd255);
    random_phase(150);

    write_threshold(REG_HUE_THRESHOLD, PixW'($urandom_range(255)));
    write_threshold(REG_SAT_THRESHOLD, PixW'($urandom_range(255)));
    random_phase(150);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_threshold(REG_HUE_THRESHOLD, PixW'($urandom_range(200, 0)));
    write_threshold(REG_SAT_THRESHOLD, PixW'($urandom_range(120, 0)));
    hold_request = 1'b1;
    random_phase(150);

    write_threshold(REG_HUE_THRESHOLD, PixW'($urandom_range(255)));
    write_threshold(REG_SAT_THRESHOLD, PixW'($urandom_range(255)));
    random_phase(250);

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
